@@ sv/ucm_pkg.sv @@
// Shared types and constants of the UTF-8 to legacy charset mapper.
`default_nettype none
package ucm_pkg;

    localparam int unsigned MAP_ENTRIES_DEF = 256;
    localparam int unsigned FIFO_DEPTH_DEF  = 4;
    localparam int unsigned GRP_SIZE        = 32;
    localparam int unsigned GRP_BITS        = 5;
    localparam int unsigned CP_W            = 21;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned SLOT_W          = 8;
    localparam int unsigned MAX_OUT         = 4;
    localparam int unsigned HELD_N          = 3;
    localparam int unsigned APB_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic REG_IDX_MODE = 1'b0;

    localparam logic [7:0] ASCII_END = 8'h80;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] MASK_L2   = 8'h1F;
    localparam logic [7:0] MASK_L3   = 8'h0F;
    localparam logic [7:0] MASK_L4   = 8'h07;
    localparam logic [7:0] MASK_CONT = 8'h3F;
    localparam logic [7:0] MASK_TAG  = 8'hC0;

    typedef enum logic {
        KIND_TEXT  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    typedef struct packed {
        logic                          is_wr;
        logic                          lookup;
        logic [2:0]                    cnt;
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [CP_W-1:0]               key;
        logic [SLOT_W-1:0]             wr_slot;
        logic [BYTE_W-1:0]             wr_byte;
        logic                          wr_live;
    } t_job;

    typedef struct packed {
        logic              v;
        logic              hit;
        logic [BYTE_W-1:0] hval;
        t_job              job;
    } t_stage;

endpackage
`default_nettype wire

@@ sv/ucm_in_if.sv @@
// Input request channel of the mapper: text bytes and map entry writes.
`default_nettype none
interface ucm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ucm_pkg::BYTE_W-1:0]    text_byte;
    logic                          end_of_text;
    logic [ucm_pkg::SLOT_W-1:0]    entry_slot;
    logic [ucm_pkg::CP_W-1:0]      entry_codepoint;
    logic [ucm_pkg::BYTE_W-1:0]    entry_byte;
    logic                          entry_valid;

    modport source (
        output valid, kind, text_byte, end_of_text, entry_slot,
               entry_codepoint, entry_byte, entry_valid,
        input  ready
    );
    modport sink (
        input  valid, kind, text_byte, end_of_text, entry_slot,
               entry_codepoint, entry_byte, entry_valid,
        output ready
    );
endinterface
`default_nettype wire

@@ sv/ucm_out_if.sv @@
// Output request channel of the mapper: converted bytes.
`default_nettype none
interface ucm_out_if;
    logic                       valid;
    logic                       ready;
    logic [ucm_pkg::BYTE_W-1:0] out_byte;
    logic                       last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

@@ sv/ucm_fifo.sv @@
// Short job queue between the decoder front and the lookup back.
`default_nettype none
module ucm_fifo #(
    parameter int unsigned DEPTH = ucm_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ucm_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ucm_pkg::t_job o_head
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ucm_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

@@ sv/ucm_front.sv @@
// Decoder front: accepts requests, tracks UTF-8 state and builds jobs.
`default_nettype none
module ucm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_mode,
    ucm_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output ucm_pkg::t_job o_job
);
    logic [ucm_pkg::HELD_N-1:0][ucm_pkg::BYTE_W-1:0] r_held, n_held;
    logic [1:0]                                       r_hcnt, n_hcnt;
    logic [1:0]                                       r_need, n_need;
    logic [ucm_pkg::CP_W-1:0]                         r_cp, n_cp;

    logic                                             acc;
    logic [ucm_pkg::BYTE_W-1:0]                       b;
    logic                                             eot;
    logic                                             is_cont;
    logic                                             pending;
    logic                                             start_emit;
    logic [ucm_pkg::CP_W-1:0]                         cp_next;
    logic [1:0]                                       ld_need;
    logic [ucm_pkg::CP_W-1:0]                         ld_cp;
    logic [ucm_pkg::MAX_OUT-1:0][ucm_pkg::BYTE_W-1:0] fl;
    logic [2:0]                                       fl_cnt;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign b          = i_in.text_byte;
    assign eot        = i_in.end_of_text;
    assign is_cont    = ((b & ucm_pkg::MASK_TAG) == ucm_pkg::CONT_TAG);
    assign pending    = (r_need != 2'd0);
    assign start_emit = (b < ucm_pkg::LEAD2) || eot;
    assign cp_next    = {r_cp[ucm_pkg::CP_W-7:0], 6'(b & ucm_pkg::MASK_CONT)};
    assign fl_cnt     = {1'b0, r_hcnt} + 3'd1;

    always_comb begin
        if (b < ucm_pkg::LEAD3) begin
            ld_need = 2'd1;
            ld_cp   = ucm_pkg::CP_W'(b & ucm_pkg::MASK_L2);
        end else if (b < ucm_pkg::LEAD4) begin
            ld_need = 2'd2;
            ld_cp   = ucm_pkg::CP_W'(b & ucm_pkg::MASK_L3);
        end else begin
            ld_need = 2'd3;
            ld_cp   = ucm_pkg::CP_W'(b & ucm_pkg::MASK_L4);
        end
    end

    // Held bytes followed by the current byte, as a flush would emit them.
    always_comb begin
        for (int i = 0; i < ucm_pkg::HELD_N; i++) begin
            fl[i] = r_held[i];
        end
        fl[ucm_pkg::MAX_OUT-1] = '0;
        fl[r_hcnt] = b;
    end

    always_comb begin
        n_held = r_held;
        n_hcnt = r_hcnt;
        n_need = r_need;
        n_cp   = r_cp;
        o_push = 1'b0;
        o_job  = '0;
        if (acc) begin
            if (i_in.kind == ucm_pkg::KIND_WRITE) begin
                o_push        = 1'b1;
                o_job.is_wr   = 1'b1;
                o_job.wr_slot = i_in.entry_slot;
                o_job.key     = i_in.entry_codepoint;
                o_job.wr_byte = i_in.entry_byte;
                o_job.wr_live = i_in.entry_valid;
            end else if (!i_mode) begin
                o_push      = 1'b1;
                o_job.bytes = fl;
                o_job.cnt   = fl_cnt;
                n_hcnt      = 2'd0;
                n_need      = 2'd0;
                n_cp        = '0;
            end else if (!pending || !is_cont) begin
                if (start_emit) begin
                    o_push      = 1'b1;
                    o_job.bytes = fl;
                    o_job.cnt   = fl_cnt;
                    n_hcnt      = 2'd0;
                    n_need      = 2'd0;
                    n_cp        = '0;
                end else begin
                    o_push      = pending;
                    o_job.bytes = fl;
                    o_job.cnt   = {1'b0, r_hcnt};
                    n_held[0]   = b;
                    n_hcnt      = 2'd1;
                    n_need      = ld_need;
                    n_cp        = ld_cp;
                end
            end else if (r_need == 2'd1) begin
                o_push = 1'b1;
                if (cp_next < ucm_pkg::CP_W'(ucm_pkg::ASCII_END)) begin
                    o_job.bytes[0] = cp_next[ucm_pkg::BYTE_W-1:0];
                    o_job.cnt      = 3'd1;
                end else begin
                    o_job.bytes  = fl;
                    o_job.cnt    = fl_cnt;
                    o_job.lookup = 1'b1;
                    o_job.key    = cp_next;
                end
                n_hcnt = 2'd0;
                n_need = 2'd0;
                n_cp   = '0;
            end else if (eot) begin
                o_push      = 1'b1;
                o_job.bytes = fl;
                o_job.cnt   = fl_cnt;
                n_hcnt      = 2'd0;
                n_need      = 2'd0;
                n_cp        = '0;
            end else begin
                if (r_hcnt != 2'd3) begin
                    n_held[r_hcnt] = b;
                end
                n_hcnt = r_hcnt + 2'd1;
                n_need = r_need - 2'd1;
                n_cp   = cp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= 2'd0;
            r_need <= 2'd0;
            r_cp   <= '0;
        end else begin
            r_hcnt <= n_hcnt;
            r_need <= n_need;
            r_cp   <= n_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule
`default_nettype wire

@@ sv/ucm_stage.sv @@
// One lookup stage: a group of map slots, matched in parallel, written in order.
`default_nettype none
module ucm_stage #(
    parameter int unsigned STAGE       = 0,
    parameter int unsigned MAP_ENTRIES = ucm_pkg::MAP_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  ucm_pkg::t_stage i_st,
    output ucm_pkg::t_stage o_st
);
    localparam int unsigned G = ucm_pkg::GRP_SIZE;

    logic [ucm_pkg::CP_W-1:0]   r_key [G];
    logic [ucm_pkg::BYTE_W-1:0] r_val [G];
    logic [G-1:0]               r_live;

    logic                       r_v;
    logic                       r_hit;
    logic [ucm_pkg::BYTE_W-1:0] r_hval;
    ucm_pkg::t_job              r_job;

    logic [G-1:0]               m;
    logic [G-1:0]               first;
    logic [ucm_pkg::BYTE_W-1:0] hv;
    logic                       wr_here;
    logic [ucm_pkg::GRP_BITS-1:0] wr_idx;

    assign wr_idx  = i_st.job.wr_slot[ucm_pkg::GRP_BITS-1:0];
    assign wr_here = i_adv && i_st.v && i_st.job.is_wr
                     && ((32'(i_st.job.wr_slot) >> ucm_pkg::GRP_BITS) == 32'(STAGE))
                     && (32'(i_st.job.wr_slot) < 32'(MAP_ENTRIES));

    always_comb begin
        for (int j = 0; j < G; j++) begin
            m[j] = r_live[j] && (r_key[j] == i_st.job.key);
        end
    end

    // Isolate the lowest matching slot, then select its byte.
    assign first = m & (~m + G'(1));

    always_comb begin
        hv = '0;
        for (int j = 0; j < G; j++) begin
            hv = hv | (first[j] ? r_val[j] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_live <= '0;
        end else begin
            if (i_adv) begin
                r_v <= i_st.v;
            end
            if (wr_here) begin
                r_live[wr_idx] <= i_st.job.wr_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_job  <= i_st.job;
            r_hit  <= i_st.hit || (i_st.job.lookup && (m != '0));
            r_hval <= i_st.hit ? i_st.hval : hv;
        end
        if (wr_here) begin
            r_key[wr_idx] <= i_st.job.key;
            r_val[wr_idx] <= i_st.job.wr_byte;
        end
    end

    assign o_st.v    = r_v;
    assign o_st.hit  = r_hit;
    assign o_st.hval = r_hval;
    assign o_st.job  = r_job;

endmodule
`default_nettype wire

@@ sv/ucm_back.sv @@
// Lookup back: chain of match stages and the output byte serializer.
`default_nettype none
module ucm_back #(
    parameter int unsigned MAP_ENTRIES = ucm_pkg::MAP_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_v,
    input  ucm_pkg::t_job i_head,
    output logic          o_pop,
    ucm_out_if.source     o_out
);
    localparam int unsigned NUM_STG =
        (MAP_ENTRIES + ucm_pkg::GRP_SIZE - 1) / ucm_pkg::GRP_SIZE;

    ucm_pkg::t_stage w_st [NUM_STG+1];
    ucm_pkg::t_stage last;

    logic                                             adv;
    logic                                             last_text;
    logic                                             take;
    logic                                             is_last;
    logic                                             done;
    logic                                             ser_ok;
    logic                                             ld;

    logic                                             r_busy;
    logic [1:0]                                       r_idx;
    logic [2:0]                                       r_cnt;
    logic [ucm_pkg::MAX_OUT-1:0][ucm_pkg::BYTE_W-1:0] r_bytes, n_bytes;

    assign w_st[0].v    = i_head_v;
    assign w_st[0].hit  = 1'b0;
    assign w_st[0].hval = '0;
    assign w_st[0].job  = i_head;

    for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
        ucm_stage #(
            .STAGE       (s),
            .MAP_ENTRIES (MAP_ENTRIES)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_st    (w_st[s]),
            .o_st    (w_st[s+1])
        );
    end

    assign last      = w_st[NUM_STG];
    assign last_text = last.v && !last.job.is_wr;
    assign is_last   = (({1'b0, r_idx} + 3'd1) == r_cnt);
    assign take      = r_busy && o_out.ready;
    assign done      = take && is_last;
    assign ser_ok    = !r_busy || done;
    assign adv       = !last_text || ser_ok;
    assign ld        = last_text && ser_ok;
    assign o_pop     = adv && i_head_v;

    always_comb begin
        n_bytes = last.job.bytes;
        if (last.job.lookup && last.hit) begin
            n_bytes[0] = last.hval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_cnt  <= 3'd0;
        end else if (ld) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
            r_cnt  <= (last.job.lookup && last.hit) ? 3'd1 : last.job.cnt;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_bytes <= n_bytes;
        end
    end

    assign o_out.valid       = r_busy;
    assign o_out.out_byte    = r_bytes[r_idx];
    assign o_out.last_of_run = is_last;

endmodule
`default_nettype wire

@@ sv/utf8_to_legacy_charset_mapper.sv @@
// Top level of the UTF-8 to legacy single-byte charset mapper.
//
//  channel  direction  handshake          payload
//  i_in     request    valid/ready        kind, text_byte, end_of_text, entry_*
//  o_out    result     valid/ready        out_byte, last_of_run
//  apb      config     psel/penable       mode at byte address 0
//
// One request per cycle is accepted while the job queue (default depth 4) has room.
// Results leave one byte per cycle while o_out is ready, each job's bytes as one run.
// A code point lookup passes ceil(MAP_ENTRIES/32) registered match stages.
// Reset is synchronous and clears the decoder, queue, pipeline and all slot live bits.
// A stalled output stops the match stages; the queue then fills and drops ready.
`default_nettype none
module utf8_to_legacy_charset_mapper #(
    parameter int unsigned MAP_ENTRIES = ucm_pkg::MAP_ENTRIES_DEF,
    parameter int unsigned FIFO_DEPTH  = ucm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ucm_in_if.sink                             i_in,
    ucm_out_if.source                          o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ucm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ucm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ucm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    logic          r_mode;
    logic          cfg_wr;
    logic          reg_idx;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    ucm_pkg::t_job w_job;
    ucm_pkg::t_job w_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ucm_pkg::APB_ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == ucm_pkg::REG_IDX_MODE)
                     ? {{(ucm_pkg::APB_DATA_W-1){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (cfg_wr && reg_idx == ucm_pkg::REG_IDX_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    ucm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    ucm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ucm_back #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head_v (!w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_of_run) |=> o_out.valid)
        else $error("A result run was interrupted before its last byte.");

    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && reg_idx == ucm_pkg::REG_IDX_MODE) |=> (r_mode == $past(pwdata[0])))
        else $error("The mode register did not take the written value.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !w_pop))
        else $error("Output or queue activity right after reset.");

endmodule
`default_nettype wire
